// ----- hdl/csc_pkg.sv -----
// ----------------------------------------------------------------------------
// csc_pkg - shared types and constants for the comet shimmer color block
// Sequencer states, register indexes, color constants and the divide-by-255
// helper used when blending each channel.
// ----------------------------------------------------------------------------
package csc_pkg;

	// Field and register widths fixed by the interface
	localparam int COLUMN_W  = 10;
	localparam int CH_W      = 8;
	localparam int V_W       = 8;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRAIL_DIV = 2'd2;

	// Register reset values
	localparam logic [10:0]        NUM_COLS_RST  = 11'd80;
	localparam logic signed [11:0] HEAD_STEP_RST = -12'sd6;
	localparam logic [10:0]        TRAIL_DIV_RST = 11'd1;

	// Comet geometry
	localparam int LEAD_SHIFT = 4;
	localparam int LEAD_MIN   = 2;
	localparam int TRAIL_MIN  = 8;

	// Dim base color and span up to the head color
	localparam logic [CH_W-1:0] RED_BASE = 8'd15;
	localparam logic [CH_W-1:0] RED_SPAN = 8'd240;
	localparam logic [CH_W-1:0] GRN_BASE = 8'd12;
	localparam logic [CH_W-1:0] GRN_SPAN = 8'd208;
	localparam logic [CH_W-1:0] BLU_BASE = 8'd10;
	localparam logic [CH_W-1:0] BLU_SPAN = 8'd190;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TDIV,
		ST_TDIV_WAIT,
		ST_WRAP,
		ST_SEL,
		ST_MUL1,
		ST_MUL2,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_BLEND,
		ST_BLEND_WAIT,
		ST_OUT,
		ST_HEAD,
		ST_HEAD_WAIT
	} csc_state_t;

	// floor(x / 255) for x below 65280
	function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
		return t[15:8];
	endfunction

endpackage

// ----- hdl/csc_if.sv -----
// ----------------------------------------------------------------------------
// csc_if - request and result channels of the comet shimmer color block
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface csc_col_if import csc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [COLUMN_W-1:0] column;
	logic                frame_end;

	modport source(output valid, output column, output frame_end, input ready);
	modport sink(input valid, input column, input frame_end, output ready);
endinterface

interface csc_color_if import csc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;
	logic            color_changed;

	modport source(output valid, output red, output green, output blue,
		output color_changed, input ready);
	modport sink(input valid, input red, input green, input blue,
		input color_changed, output ready);
endinterface

// ----- hdl/csc_smul.sv -----
// ----------------------------------------------------------------------------
// csc_smul - bit-serial shift-add multiplier
// Consumes one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module csc_smul import csc_pkg::*; #(
	parameter int AW = 8,
	parameter int BW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [AW-1:0]   a,
	input  logic [BW-1:0]   b,
	output logic            busy,
	output logic [AW+BW-1:0] prod
);

	localparam int PW  = AW + BW;
	localparam int CTW = $clog2(BW + 1);

	logic [CTW-1:0] cnt_q;
	logic [PW-1:0]  a_q;
	logic [BW-1:0]  b_q;
	logic [PW-1:0]  prod_q;

	// Count remaining multiplier bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CTW'(BW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CTW'(1);
		end
	end

	// Add the shifted multiplicand for each set bit
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= PW'(a);
			b_q    <= b;
			prod_q <= '0;
		end else if (cnt_q != '0) begin
			if (b_q[0]) begin
				prod_q <= prod_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy = (cnt_q != '0);
	assign prod = prod_q;

endmodule

// ----- hdl/csc_div.sv -----
// ----------------------------------------------------------------------------
// csc_div - restoring divider, one quotient bit per cycle
// Starts from a given partial remainder and shifts in the numerator bits MSB
// first, so a division with a known short quotient runs only that many steps.
// ----------------------------------------------------------------------------
module csc_div import csc_pkg::*; #(
	parameter int LW  = 12,
	parameter int DW  = 33,
	parameter int CTW = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DW-1:0]  rem_init,
	input  logic [LW-1:0]  num,
	input  logic [DW-1:0]  den,
	input  logic [CTW-1:0] count,
	output logic           busy,
	output logic [LW-1:0]  quot,
	output logic [DW-1:0]  rem
);

	logic [CTW-1:0] cnt_q;
	logic [DW-1:0]  rem_q;
	logic [LW-1:0]  num_q;
	logic [LW-1:0]  quot_q;
	logic [DW-1:0]  den_q;

	logic [DW:0]    shifted;
	logic [DW+1:0]  diff;
	logic           fits;

	// Trial subtract of the divisor from the shifted remainder
	always_comb begin
		shifted = {rem_q, num_q[LW-1]};
		diff    = {1'b0, shifted} - {2'b00, den_q};
		fits    = !diff[DW+1];
	end

	// Count remaining quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= count;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CTW'(1);
		end
	end

	// Advance one quotient bit
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			num_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q  <= fits ? diff[DW-1:0] : shifted[DW-1:0];
			num_q  <= num_q << 1;
			quot_q <= {quot_q[LW-2:0], fits};
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ----- hdl/comet_shimmer_color.sv -----
// ----------------------------------------------------------------------------
// comet_shimmer_color - color of one column of a moving comet highlight
// Requests on col_req carry a column and a frame-end mark; each request gives
// one result on color_rsp with the red, green and blue channels and a flag set
// when the color differs from the previous column's (always set at column 0).
// Registers are written on cfg_we with cfg_index/cfg_data (0 column count,
// 1 signed head step per frame, 2 trail divisor); the user must write them
// only while idle, which the block itself does not enforce.
// One request is in work at a time; a frame-end request adds the head update.
// The work is done by the bit-serial units: the trail half-width division and
// the head modulo (one bit per cycle over the divider's numerator width), two
// passes of the serial multipliers (one bit per cycle over the column-count
// width) and the 8-step intensity division, for a column inside the comet only,
// and the 8-step channel blend for every column.
// The result waits in an output register; while the receiver stalls, the
// sequencer holds at the result step and then finishes the head update.
// Reset restores the register defaults (80 columns, step -6, divisor 1),
// puts the head at column 0 and clears the previous color.
// ----------------------------------------------------------------------------
module comet_shimmer_color import csc_pkg::*; #(
	parameter int MAX_COLS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	csc_col_if.sink              col_req,
	csc_color_if.source          color_rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CNW  = $clog2(MAX_COLS + 1);
	localparam int HPW  = $clog2(MAX_COLS);
	localparam int MW   = $clog2(MAX_COLS + 2047);
	localparam int LW   = MW;
	localparam int SSW  = MW + 1;
	localparam int DW   = 3 * CNW;
	localparam int NW   = DW + V_W;
	localparam int CTW  = $clog2(LW + 1);
	localparam int DSW  = ((CNW > COLUMN_W) ? CNW : COLUMN_W) + 2;
	localparam int CMPW = (CNW > 11) ? CNW : 11;

	// Configuration registers
	logic [10:0]        num_cols_q;
	logic signed [11:0] head_step_q;
	logic [10:0]        trail_div_q;

	// Sequencer and per-request state
	csc_state_t          state_q, state_d;
	logic [COLUMN_W-1:0] col_q;
	logic                fe_q;
	logic [HPW-1:0]      head_q;
	logic [CNW-1:0]      tail_hw_q;
	logic signed [DSW-1:0] delta_q;
	logic                lead_q;
	logic [CNW-1:0]      d_q;
	logic [CNW-1:0]      h_q;
	logic [2*CNW-1:0]    d2_q;
	logic [2*CNW-1:0]    h2_q;
	logic [NW-1:0]       n_q;
	logic [DW-1:0]       den_q;
	logic [V_W-1:0]      v_q;
	logic [3*CH_W-1:0]   prev_q;

	// Output register
	logic                out_valid_q;
	logic [CH_W-1:0]     red_q, green_q, blue_q;
	logic                changed_q;

	// Derived geometry
	logic [CNW-1:0]      cols;
	logic [CNW-1:0]      half;
	logic [CNW-1:0]      hw_lead;
	logic [CNW-1:0]      lead_raw;
	logic [10:0]         tdiv;

	// Wrap and selection
	logic signed [DSW-1:0] half_s, cols_s;
	logic signed [DSW-1:0] dw0, dw1, dw2;
	logic [DSW-1:0]      dist_abs;
	logic                step_pos;
	logic                lead;
	logic [CNW-1:0]      hw;
	logic                in_range;
	logic [CNW-1:0]      d;

	// Head update
	logic signed [SSW-1:0] sum;
	logic [SSW-1:0]      mag;
	logic [CNW-1:0]      hrem;

	// Result forming
	logic [3*CNW-1:0]    num_x;
	logic [CH_W-1:0]     red_c, green_c, blue_c;
	logic [3*CH_W-1:0]   color_c;

	// Unit controls
	logic                div_start;
	logic [DW-1:0]       div_rem_init;
	logic [LW-1:0]       div_num;
	logic [DW-1:0]       div_den;
	logic [CTW-1:0]      div_count;
	logic                div_busy;
	logic [LW-1:0]       div_quot;
	logic [DW-1:0]       div_rem;

	logic                mul_start;
	logic                mul_pass2;
	logic [2*CNW-1:0]    nmul_a, dmul_a;
	logic [CNW-1:0]      nmul_b, dmul_b;
	logic                nmul_busy, dmul_busy, mul_busy;
	logic [3*CNW-1:0]    nmul_prod, dmul_prod;

	logic                blend_start;
	logic                rmul_busy, gmul_busy, bmul_busy, blend_busy;
	logic [2*CH_W-1:0]   rmul_prod, gmul_prod, bmul_prod;

	logic                out_load;
	logic                req_accept;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q  <= NUM_COLS_RST;
			head_step_q <= HEAD_STEP_RST;
			trail_div_q <= TRAIL_DIV_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_COLS:  num_cols_q  <= cfg_data[10:0];
				REG_HEAD_STEP: head_step_q <= $signed(cfg_data[11:0]);
				REG_TRAIL_DIV: trail_div_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// Clamp the column count, form the lead half-width
	always_comb begin
		if (num_cols_q == '0) begin
			cols = CNW'(1);
		end else if (CMPW'(num_cols_q) > CMPW'(MAX_COLS)) begin
			cols = CNW'(MAX_COLS);
		end else begin
			cols = CNW'(num_cols_q);
		end
		half     = cols >> 1;
		lead_raw = cols >> LEAD_SHIFT;
		hw_lead  = (lead_raw < CNW'(LEAD_MIN)) ? CNW'(LEAD_MIN) : lead_raw;
		tdiv     = (trail_div_q == '0) ? 11'd1 : trail_div_q;
	end

	// Wrap the signed distance to the head once in each direction
	always_comb begin
		half_s = $signed({{(DSW-CNW){1'b0}}, half});
		cols_s = $signed({{(DSW-CNW){1'b0}}, cols});
		dw0 = $signed({{(DSW-COLUMN_W){1'b0}}, col_q}) - $signed({{(DSW-HPW){1'b0}}, head_q});
		dw1 = (dw0 > half_s) ? dw0 - cols_s : dw0;
		dw2 = (dw1 < -half_s) ? dw1 + cols_s : dw1;
	end

	// Pick the side, half-width and remaining depth into the comet
	always_comb begin
		dist_abs = (delta_q < 0) ? DSW'(-delta_q) : DSW'(delta_q);
		step_pos = (head_step_q > 12'sd0);
		lead     = step_pos ? (delta_q > 0) : (delta_q < 0);
		hw       = lead ? hw_lead : tail_hw_q;
		in_range = (DSW'(hw) > dist_abs);
		d        = hw - dist_abs[CNW-1:0];
	end

	// Head plus step, split into sign and magnitude for the modulo
	always_comb begin
		sum  = $signed({{(SSW-HPW){1'b0}}, head_q})
			+ $signed({{(SSW-12){head_step_q[11]}}, head_step_q});
		mag  = (sum < 0) ? SSW'(-sum) : SSW'(sum);
		hrem = div_rem[CNW-1:0];
	end

	// Blend each channel from the dim base
	always_comb begin
		num_x   = lead_q ? (3*CNW)'(d2_q) : nmul_prod;
		red_c   = RED_BASE + div255(rmul_prod);
		green_c = GRN_BASE + div255(gmul_prod);
		blue_c  = BLU_BASE + div255(bmul_prod);
		color_c = {red_c, green_c, blue_c};
	end

	assign mul_busy   = nmul_busy | dmul_busy;
	assign blend_busy = rmul_busy | gmul_busy | bmul_busy;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:       if (col_req.valid) state_d = ST_TDIV;
			ST_TDIV:       state_d = ST_TDIV_WAIT;
			ST_TDIV_WAIT:  if (!div_busy) state_d = ST_WRAP;
			ST_WRAP:       state_d = ST_SEL;
			ST_SEL:        state_d = in_range ? ST_MUL1 : ST_BLEND;
			ST_MUL1:       if (!mul_busy) state_d = ST_MUL2;
			ST_MUL2:       if (!mul_busy) state_d = ST_DIV_GO;
			ST_DIV_GO:     state_d = ST_DIV_WAIT;
			ST_DIV_WAIT:   if (!div_busy) state_d = ST_BLEND;
			ST_BLEND:      state_d = ST_BLEND_WAIT;
			ST_BLEND_WAIT: if (!blend_busy) state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || color_rsp.ready) begin
					state_d = fe_q ? ST_HEAD : ST_IDLE;
				end
			end
			ST_HEAD:       state_d = ST_HEAD_WAIT;
			ST_HEAD_WAIT:  if (!div_busy) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: unit starts and operand selection
	always_comb begin
		col_req.ready = 1'b0;
		div_start     = 1'b0;
		div_rem_init  = '0;
		div_num       = '0;
		div_den       = '0;
		div_count     = '0;
		mul_start     = 1'b0;
		mul_pass2     = 1'b0;
		blend_start   = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: col_req.ready = 1'b1;
			ST_TDIV: begin
				div_start = 1'b1;
				div_num   = LW'(cols);
				div_den   = DW'(tdiv);
				div_count = CTW'(LW);
			end
			ST_SEL: mul_start = in_range;
			ST_MUL1: begin
				mul_start = !mul_busy;
				mul_pass2 = 1'b1;
			end
			ST_DIV_GO: begin
				div_start    = 1'b1;
				div_rem_init = n_q[NW-1:V_W];
				div_num      = {n_q[V_W-1:0], {(LW-V_W){1'b0}}};
				div_den      = den_q;
				div_count    = CTW'(V_W);
			end
			ST_BLEND: blend_start = 1'b1;
			ST_OUT:   out_load = !out_valid_q || color_rsp.ready;
			ST_HEAD: begin
				div_start = 1'b1;
				div_num   = mag[LW-1:0];
				div_den   = DW'(cols);
				div_count = CTW'(LW);
			end
			default: ;
		endcase
	end

	assign req_accept = col_req.valid && col_req.ready;

	// Multiplier operands: first pass squares, second pass cubes
	always_comb begin
		nmul_a = mul_pass2 ? nmul_prod[2*CNW-1:0] : (2*CNW)'(d);
		nmul_b = mul_pass2 ? d_q : d;
		dmul_a = mul_pass2 ? dmul_prod[2*CNW-1:0] : (2*CNW)'(hw);
		dmul_b = mul_pass2 ? h_q : hw;
	end

	// Head position, previous color and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				prev_q      <= color_c;
			end else if (color_rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_HEAD_WAIT && !div_busy) begin
				head_q <= (sum < 0 && hrem != '0) ? HPW'(cols - hrem) : HPW'(hrem);
			end
		end
	end

	// Capture per-request working values
	always_ff @(posedge clk) begin
		if (req_accept) begin
			col_q <= col_req.column;
			fe_q  <= col_req.frame_end;
		end
		if (state_q == ST_TDIV_WAIT && !div_busy) begin
			tail_hw_q <= (div_quot < LW'(TRAIL_MIN)) ? CNW'(TRAIL_MIN) : CNW'(div_quot);
		end
		if (state_q == ST_WRAP) begin
			delta_q <= dw2;
		end
		if (state_q == ST_SEL) begin
			lead_q <= lead;
			d_q    <= d;
			h_q    <= hw;
			if (!in_range) begin
				v_q <= '0;
			end
		end
		if (state_q == ST_MUL1 && !mul_busy) begin
			d2_q <= nmul_prod[2*CNW-1:0];
			h2_q <= dmul_prod[2*CNW-1:0];
		end
		if (state_q == ST_MUL2 && !mul_busy) begin
			n_q   <= {num_x, {V_W{1'b0}}} - NW'(num_x);
			den_q <= lead_q ? DW'(h2_q) : dmul_prod;
		end
		if (state_q == ST_DIV_WAIT && !div_busy) begin
			v_q <= div_quot[V_W-1:0];
		end
		if (out_load) begin
			red_q     <= red_c;
			green_q   <= green_c;
			blue_q    <= blue_c;
			changed_q <= (col_q == '0) || (color_c != prev_q);
		end
	end

	// Shared divider: trail half-width, intensity ratio, head modulo
	csc_div #(
		.LW  (LW),
		.DW  (DW),
		.CTW (CTW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem_init),
		.num      (div_num),
		.den      (div_den),
		.count    (div_count),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Numerator lane: powers of the depth into the comet
	csc_smul #(
		.AW (2*CNW),
		.BW (CNW)
	) u_nmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (nmul_a),
		.b      (nmul_b),
		.busy   (nmul_busy),
		.prod   (nmul_prod)
	);

	// Denominator lane: powers of the half-width
	csc_smul #(
		.AW (2*CNW),
		.BW (CNW)
	) u_dmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (dmul_a),
		.b      (dmul_b),
		.busy   (dmul_busy),
		.prod   (dmul_prod)
	);

	// Channel blend: span times intensity
	csc_smul #(.AW(CH_W), .BW(V_W)) u_rmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (blend_start),
		.a      (RED_SPAN),
		.b      (v_q),
		.busy   (rmul_busy),
		.prod   (rmul_prod)
	);

	csc_smul #(.AW(CH_W), .BW(V_W)) u_gmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (blend_start),
		.a      (GRN_SPAN),
		.b      (v_q),
		.busy   (gmul_busy),
		.prod   (gmul_prod)
	);

	csc_smul #(.AW(CH_W), .BW(V_W)) u_bmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (blend_start),
		.a      (BLU_SPAN),
		.b      (v_q),
		.busy   (bmul_busy),
		.prod   (bmul_prod)
	);

	// Drive the result channel from the output register
	assign color_rsp.valid         = out_valid_q;
	assign color_rsp.red           = red_q;
	assign color_rsp.green         = green_q;
	assign color_rsp.blue          = blue_q;
	assign color_rsp.color_changed = changed_q;

endmodule
